// ----- rtl/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// itoa_pkg
// Types and constants shared by the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 6;
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = 10;
	localparam int BIT_CNT_W  = $clog2(VALUE_W);
	localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

	localparam logic [CHAR_W-1:0]  DIGIT_BASE    = 6'd48;
	localparam logic [CHAR_W-1:0]  MINUS_CHAR    = 6'd45;
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ     = 4'd3;

	typedef struct packed {
		logic clear;
		logic dabble;
		logic shift_out;
	} cell_ctrl_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/itoa_cell.sv -----
// ----------------------------------------------------------------------------
// itoa_cell
// One BCD digit of the conversion chain: shift-add-3 step while the binary
// magnitude is shifted in, then a plain digit shift toward the top for output.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_cell (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire itoa_pkg::cell_ctrl_t           ctrl,
	input  wire logic                           carry_in,
	input  wire logic [itoa_pkg::DIGIT_W-1:0]   digit_in,
	output logic                                carry_out,
	output logic [itoa_pkg::DIGIT_W-1:0]        digit
);
	import itoa_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	assign adj       = (digit_q >= DIGIT_ADJ_MIN) ? digit_q + DIGIT_ADJ : digit_q;
	assign carry_out = adj[DIGIT_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[DIGIT_W-2:0], carry_in};
		end else if (ctrl.shift_out) begin
			digit_q <= digit_in;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/signed_int_to_decimal_ascii_core.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts one signed 32-bit value into its decimal ASCII text.
//
// A request on the value channel (value_valid, value_stall) carries one
// two's complement integer. The block answers on the char channel
// (char_valid, char_stall) with one character per item, most significant
// first: an optional '-' and then the digits, leading zeros dropped, zero
// giving a single '0'. last_char marks the final character of the text.
// Conversion runs a chain of ten BCD digit cells, shift-add-3, one bit of
// the magnitude per cycle. Leading zero digits are then shifted out at
// one a cycle (up to 9), the first digit to send is then found, and each
// character leaves in its own cycle while char_stall is low, 1 to 11 of
// them. One request is worked on at a time, so the next request is
// accepted only after the last character of the current one is taken;
// value_stall is high from acceptance until the last character is taken.
// While a character is offered and char_stall is high, it and all state hold.
// Reset returns the block to idle and discards any request in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            value_valid,
	output logic                                 value_stall,
	input  wire logic signed [itoa_pkg::VALUE_W-1:0] value,
	output logic                                 char_valid,
	input  wire logic                            char_stall,
	output logic [itoa_pkg::CHAR_W-1:0]          text_char,
	output logic                                 last_char
);
	import itoa_pkg::*;

	state_t                 state_q;
	logic [VALUE_W-1:0]     mag_q;
	logic                   neg_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIG_CNT_W-1:0]   dig_cnt_q;
	cell_ctrl_t             ctrl;
	logic                   accept;
	logic                   advance;
	logic                   skip_zero;

	logic [DIGIT_W-1:0]     digit_w [NUM_DIGITS];
	logic                   carry_w [NUM_DIGITS];
	logic [DIGIT_W-1:0]     top_digit;

	assign accept      = value_valid && !value_stall;
	assign value_stall = (state_q != ST_IDLE);
	assign char_valid  = (state_q == ST_SIGN) || (state_q == ST_EMIT);
	assign advance     = char_valid && !char_stall;
	assign top_digit   = digit_w[NUM_DIGITS-1];
	assign skip_zero   = (top_digit == '0) && (dig_cnt_q > DIG_CNT_W'(1));

	assign text_char = (state_q == ST_SIGN) ? MINUS_CHAR
	                                         : DIGIT_BASE + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
	assign last_char = (state_q == ST_EMIT) && (dig_cnt_q == DIG_CNT_W'(1));

	always_comb begin
		ctrl.clear     = accept;
		ctrl.dabble    = (state_q == ST_CONV);
		ctrl.shift_out = ((state_q == ST_SKIP) && skip_zero)
		              || ((state_q == ST_EMIT) && advance);
	end

	genvar gi;
	generate
		for (gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
			logic               cin;
			logic [DIGIT_W-1:0] din;
			if (gi == 0) begin : g_first
				assign cin = mag_q[VALUE_W-1];
				assign din = '0;
			end else begin : g_rest
				assign cin = carry_w[gi-1];
				assign din = digit_w[gi-1];
			end
			itoa_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.carry_in  (cin),
				.digit_in  (din),
				.carry_out (carry_w[gi]),
				.digit     (digit_w[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
			neg_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q     <= value[VALUE_W-1];
						bit_cnt_q <= BIT_CNT_W'(VALUE_W - 1);
						dig_cnt_q <= DIG_CNT_W'(NUM_DIGITS);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
					if (bit_cnt_q == '0) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (skip_zero) begin
						dig_cnt_q <= dig_cnt_q - DIG_CNT_W'(1);
					end else if (neg_q) begin
						state_q <= ST_SIGN;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (advance) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (advance) begin
						dig_cnt_q <= dig_cnt_q - DIG_CNT_W'(1);
						if (dig_cnt_q == DIG_CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= value[VALUE_W-1] ? VALUE_W'(-value) : VALUE_W'(value);
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
		end
	end

	a_busy_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> value_stall)
		else $error("request accepted while text is being emitted");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_char) |=> (!char_valid && !value_stall))
		else $error("block not idle after last character");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (top_digit <= 4'd9))
		else $error("cell chain holds a non-decimal digit");

	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && $past(state_q != ST_EMIT) && (dig_cnt_q > DIG_CNT_W'(1)))
		|-> (top_digit != '0))
		else $error("leading zero emitted");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (dig_cnt_q != '0))
		else $error("character emitted with no digits left");

endmodule

`default_nettype wire
